@@ hdl/pow_nonce_blake2b_hasher_macros.svh @@
// Assertion macros for the nonce hasher
`ifndef POW_NONCE_BLAKE2B_HASHER_MACROS_SVH
`define POW_NONCE_BLAKE2B_HASHER_MACROS_SVH
`ifndef SYNTH
`define PNB_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("pnb assertion failed");
`define PNB_ASSERT_NXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("pnb assertion failed");
`else
`define PNB_ASSERT_IMP(label, lhs, rhs)
`define PNB_ASSERT_NXT(label, lhs, rhs)
`endif
`endif

@@ hdl/pnb_pkg.sv @@
package pnb_pkg;

    localparam int TPL_WORDS = 12;
    localparam int MSG_BYTES = 80;
    localparam int DIGEST_BYTES = 32;
    localparam int ROUNDS = 12;
    localparam int PHASES = 4;
    localparam int CELLS = ROUNDS * PHASES;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_HASH = 1'b1;
    localparam logic [1:0] PROFILE_NONCE_FIRST = 2'd1;

    localparam logic [7:0][63:0] IV = {
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
        64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0000 ^ 64'(DIGEST_BYTES);

    localparam logic [3:0] SIGMA [ROUNDS][16] = '{
        '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
        '{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3},
        '{11,8,12,0,5,2,15,13,10,14,3,6,7,1,9,4},
        '{7,9,3,1,13,12,11,14,2,6,5,10,4,0,15,8},
        '{9,0,5,7,2,4,10,15,14,1,11,12,6,8,3,13},
        '{2,12,6,10,0,11,8,3,4,13,7,5,15,14,1,9},
        '{12,5,1,15,14,13,4,10,0,7,6,3,9,2,8,11},
        '{13,11,7,14,12,1,3,9,5,0,15,4,8,6,2,10},
        '{6,15,14,9,11,3,0,8,12,2,13,7,1,4,10,5},
        '{10,2,8,4,7,6,1,5,15,11,9,14,3,12,13,0},
        '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
        '{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3}
    };

    typedef struct packed {
        logic        kind;
        logic [3:0]  word_index;
        logic [63:0] word_data;
        logic [31:0] nonce_a;
        logic [31:0] nonce_b;
        logic [31:0] nonce_c;
        logic [31:0] time_shift;
    } req_word_t;

    typedef struct packed {
        logic [63:0] hash_word0;
        logic [63:0] hash_word1;
        logic [63:0] hash_word2;
        logic [63:0] hash_word3;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0][63:0] v;
        logic [15:0][63:0] m;
        logic [3:0][63:0]  mask;
    } pipe_t;

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

@@ hdl/pnb_cell.sv @@
module pnb_cell
    import pnb_pkg::*;
#(
    parameter int ROUND = 0,
    parameter int PHASE = 0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  vld_in,
    input  pipe_t din,
    output logic  vld_out,
    output pipe_t dout
);

    localparam bit DIAG = (PHASE >= 2);
    localparam bit SECOND = ((PHASE % 2) == 1);
    localparam int ROT_D = SECOND ? 16 : 32;
    localparam int ROT_B = SECOND ? 63 : 24;
    localparam int MSG_BASE = (DIAG ? 8 : 0) + (SECOND ? 1 : 0);

    logic  vld_reg;
    pipe_t data_reg;
    pipe_t data_next;

    always_comb
    begin
        data_next = din;
        for (int j = 0; j < 4; j++)
        begin
            int ia;
            int ib;
            int ic;
            int id;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] c;
            logic [63:0] d;
            ia = j;
            ib = DIAG ? 4 + ((j + 1) % 4) : 4 + j;
            ic = DIAG ? 8 + ((j + 2) % 4) : 8 + j;
            id = DIAG ? 12 + ((j + 3) % 4) : 12 + j;
            a = din.v[ia] + din.v[ib] + din.m[SIGMA[ROUND][MSG_BASE + 2 * j]];
            d = rotr64(din.v[id] ^ a, ROT_D);
            c = din.v[ic] + d;
            b = rotr64(din.v[ib] ^ c, ROT_B);
            data_next.v[ia] = a;
            data_next.v[ib] = b;
            data_next.v[ic] = c;
            data_next.v[id] = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign vld_out = vld_reg;
    assign dout = data_reg;

endmodule

@@ hdl/pow_nonce_blake2b_hasher.sv @@
// A hash word passes through one pack stage, 48 mix cells of four half-G steps
// each and one output stage before its result word is raised.
// Throughput: one word per cycle; the whole cell chain advances together and
// holds while the output register waits. Load words give no result.
// Reset: rst_n clears valid flags and profile_reg; template words hold
// nothing until written.
`include "pow_nonce_blake2b_hasher_macros.svh"

module pow_nonce_blake2b_hasher
    import pnb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_data
);

    logic [1:0]  profile_reg;
    logic [63:0] tpl_reg [TPL_WORDS];
    logic        adv;
    logic        req_fire;
    logic        vld_chain [CELLS + 1];
    pipe_t       pipe_chain [CELLS + 1];
    pipe_t       pack_next;
    logic        pack_vld_reg;
    pipe_t       pack_reg;
    logic        rsp_valid_reg;
    rsp_word_t   rsp_reg;
    rsp_word_t   rsp_next;

    assign adv = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;
    assign req_fire = req_valid && adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg <= 2'd0;
        end
        else if (cfg_valid)
        begin
            profile_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && req.kind == KIND_LOAD && req.word_index < 4'(TPL_WORDS))
        begin
            tpl_reg[req.word_index] <= req.word_data;
        end
    end

    always_comb
    begin
        logic [255:0]      prev;
        logic [255:0]      prev_rev;
        logic [15:0][63:0] m;
        prev = {tpl_reg[3], tpl_reg[2], tpl_reg[1], tpl_reg[0]};
        for (int i = 0; i < 32; i++)
        begin
            prev_rev[8 * i +: 8] = prev[8 * (31 - i) +: 8];
        end
        m = '0;
        if (profile_reg == PROFILE_NONCE_FIRST)
        begin
            m[0] = {req.nonce_b, req.nonce_a};
            m[1] = {req.time_shift, req.nonce_c};
            for (int i = 0; i < 4; i++)
            begin
                m[2 + i] = tpl_reg[4 + i];
                m[6 + i] = prev_rev[64 * i +: 64];
            end
        end
        else
        begin
            m[4] = {req.nonce_b, req.nonce_a};
            m[5] = {req.nonce_c, req.time_shift};
            for (int i = 0; i < 4; i++)
            begin
                m[i] = prev_rev[64 * i +: 64];
                m[6 + i] = tpl_reg[4 + i];
            end
        end
        pack_next.m = m;
        for (int i = 0; i < 8; i++)
        begin
            pack_next.v[i] = IV[i];
            pack_next.v[8 + i] = IV[i];
        end
        pack_next.v[0] = IV[0] ^ PARAM_WORD;
        pack_next.v[12] = IV[4] ^ 64'(MSG_BYTES);
        pack_next.v[14] = ~IV[6];
        for (int i = 0; i < 4; i++)
        begin
            pack_next.mask[i] = tpl_reg[8 + i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pack_vld_reg <= req_valid && req.kind == KIND_HASH;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pack_reg <= pack_next;
        end
    end

    assign vld_chain[0] = pack_vld_reg;
    assign pipe_chain[0] = pack_reg;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        pnb_cell #(
            .ROUND(k / PHASES),
            .PHASE(k % PHASES)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vld_in  (vld_chain[k]),
            .din     (pipe_chain[k]),
            .vld_out (vld_chain[k + 1]),
            .dout    (pipe_chain[k + 1])
        );
    end

    always_comb
    begin
        logic [255:0] dig;
        logic [255:0] fin;
        pipe_t        last;
        logic [63:0]  h0;
        last = pipe_chain[CELLS];
        for (int i = 0; i < 4; i++)
        begin
            h0 = (i == 0) ? (IV[0] ^ PARAM_WORD) : IV[i];
            dig[64 * i +: 64] = h0 ^ last.v[i] ^ last.v[8 + i] ^ last.mask[i];
        end
        for (int i = 0; i < DIGEST_BYTES; i++)
        begin
            fin[8 * i +: 8] = dig[8 * (DIGEST_BYTES - 1 - i) +: 8];
        end
        rsp_next.hash_word0 = fin[63:0];
        rsp_next.hash_word1 = fin[127:64];
        rsp_next.hash_word2 = fin[191:128];
        rsp_next.hash_word3 = fin[255:192];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= vld_chain[CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    `PNB_ASSERT_IMP(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)
    `PNB_ASSERT_NXT(a_stall_holds_tail, !req_ready, $stable(vld_chain[CELLS]))
    `PNB_ASSERT_NXT(a_load_no_entry, req_valid && req_ready && req.kind == KIND_LOAD,
                    !pack_vld_reg)

endmodule

@@ tb/sv/tb_pow_nonce_blake2b_hasher.sv @@
module tb_pow_nonce_blake2b_hasher;
    import pnb_pkg::*;

    localparam int LATENCY = 50;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_data;

    pow_nonce_blake2b_hasher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    logic [63:0] tpl_copy [TPL_WORDS];
    logic [1:0]  profile_copy;
    rsp_word_t   digest_queue[$];
    int          fail_count;
    int          hash_count;
    int          load_count;
    int          result_count;
    bit          send_idle_on;
    bit          recv_idle_on;
    bit          recv_hold;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        ror = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [7:0] tpl_byte(input int base, input int k);
        logic [63:0] w;
        w = tpl_copy[base + k / 8];
        tpl_byte = w[8 * (k % 8) +: 8];
    endfunction

    function automatic rsp_word_t predict_digest(input req_word_t r);
        logic [7:0]  msg [MSG_BYTES];
        logic [63:0] m [16];
        logic [63:0] v [16];
        logic [63:0] h [8];
        logic [7:0]  fin [DIGEST_BYTES];
        logic [63:0] w [4];
        logic [7:0]  d;
        int          p_off;
        int          m_off;
        int          a_off;
        int          b_off;
        int          c_off;
        int          t_off;
        int          s;
        int          g;
        int          ia;
        int          ib;
        int          ic;
        int          id;
        rsp_word_t   res;
        int          ga [8];
        int          gb [8];
        int          gc [8];
        int          gd [8];
        ga = '{0, 1, 2, 3, 0, 1, 2, 3};
        gb = '{4, 5, 6, 7, 5, 6, 7, 4};
        gc = '{8, 9, 10, 11, 10, 11, 8, 9};
        gd = '{12, 13, 14, 15, 15, 12, 13, 14};
        if (profile_copy == PROFILE_NONCE_FIRST)
        begin
            a_off = 0; b_off = 4; c_off = 8; t_off = 12; m_off = 16; p_off = 48;
        end
        else
        begin
            p_off = 0; a_off = 32; b_off = 36; t_off = 40; c_off = 44; m_off = 48;
        end
        for (int i = 0; i < 4; i++)
        begin
            msg[a_off + i] = r.nonce_a[8 * i +: 8];
            msg[b_off + i] = r.nonce_b[8 * i +: 8];
            msg[c_off + i] = r.nonce_c[8 * i +: 8];
            msg[t_off + i] = r.time_shift[8 * i +: 8];
        end
        for (int i = 0; i < 32; i++)
        begin
            msg[p_off + i] = tpl_byte(0, 31 - i);
            msg[m_off + i] = tpl_byte(4, i);
        end
        for (int i = 0; i < 16; i++)
            m[i] = '0;
        for (int i = 0; i < MSG_BYTES; i++)
            m[i / 8][8 * (i % 8) +: 8] = msg[i];
        for (int i = 0; i < 8; i++)
        begin
            h[i] = IV[i];
            v[i + 8] = IV[i];
        end
        h[0] = h[0] ^ PARAM_WORD;
        for (int i = 0; i < 8; i++)
            v[i] = h[i];
        v[12] = v[12] ^ 64'(MSG_BYTES);
        v[14] = ~v[14];
        for (int rd = 0; rd < ROUNDS; rd++)
            for (g = 0; g < 8; g++)
            begin
                ia = ga[g]; ib = gb[g]; ic = gc[g]; id = gd[g];
                s = SIGMA[rd][2 * g];
                v[ia] = v[ia] + v[ib] + m[s];
                v[id] = ror(v[id] ^ v[ia], 32);
                v[ic] = v[ic] + v[id];
                v[ib] = ror(v[ib] ^ v[ic], 24);
                s = SIGMA[rd][2 * g + 1];
                v[ia] = v[ia] + v[ib] + m[s];
                v[id] = ror(v[id] ^ v[ia], 16);
                v[ic] = v[ic] + v[id];
                v[ib] = ror(v[ib] ^ v[ic], 63);
            end
        for (int i = 0; i < 8; i++)
            h[i] = h[i] ^ v[i] ^ v[i + 8];
        for (int i = 0; i < DIGEST_BYTES; i++)
        begin
            d = h[i / 8][8 * (i % 8) +: 8];
            fin[31 - i] = d ^ tpl_byte(8, i);
        end
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 8; k++)
                w[i][8 * k +: 8] = fin[8 * i + k];
        res.hash_word0 = w[0];
        res.hash_word1 = w[1];
        res.hash_word2 = w[2];
        res.hash_word3 = w[3];
        predict_digest = res;
    endfunction

    task automatic send_word(input req_word_t r);
        int gap;
        if (send_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        if (r.kind == KIND_HASH)
        begin
            digest_queue.push_back(predict_digest(r));
            hash_count++;
        end
        else
        begin
            if (r.word_index < TPL_WORDS)
                tpl_copy[r.word_index] = r.word_data;
            load_count++;
        end
    endtask

    task automatic load_word(input logic [3:0] idx, input logic [63:0] data);
        req_word_t r;
        r.kind = KIND_LOAD;
        r.word_index = idx;
        r.word_data = data;
        r.nonce_a = $urandom;
        r.nonce_b = $urandom;
        r.nonce_c = $urandom;
        r.time_shift = $urandom;
        send_word(r);
    endtask

    task automatic hash_word(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] t);
        req_word_t r;
        r.kind = KIND_HASH;
        r.word_index = 4'($urandom_range(0, 15));
        r.word_data = {$urandom, $urandom};
        r.nonce_a = a;
        r.nonce_b = b;
        r.nonce_c = c;
        r.time_shift = t;
        send_word(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_profile(input logic [1:0] p);
        cfg_valid <= 1'b1;
        cfg_data <= p;
        do
            @(posedge clk);
        while (!cfg_ready);
        profile_copy = p;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_all_random();
        for (int i = 0; i < TPL_WORDS; i++)
            load_word(4'(i), {$urandom, $urandom});
    endtask

    task automatic test_directed();
        for (int i = 0; i < TPL_WORDS; i++)
            load_word(4'(i), 64'h0);
        hash_word('0, '0, '0, '0);
        for (int i = 0; i < TPL_WORDS; i++)
            load_word(4'(i), '1);
        hash_word('1, '1, '1, '1);
        load_word(4'd12, 64'h0123_4567_89ab_cdef);
        load_word(4'd15, '0);
        hash_word(32'h8000_0001, 32'h0000_ffff, 32'hffff_0000, 32'h1234_5678);
    endtask

    task automatic test_profiles();
        logic [1:0] order [5];
        order = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
        foreach (order[k])
        begin
            drain();
            write_profile(order[k]);
            load_all_random();
            repeat (40) hash_word($urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_backpressure();
        drain();
        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                recv_hold = 1'b0;
            end
            repeat (120) hash_word($urandom, $urandom, $urandom, $urandom);
        join
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                load_word(4'($urandom_range(0, 15)), {$urandom, $urandom});
            else
                hash_word($urandom, $urandom, $urandom, $urandom);
            if (n % 400 == 399)
            begin
                drain();
                write_profile(2'($urandom_range(0, 3)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            result_count++;
            if (digest_queue.size() == 0)
            begin
                $error("unexpected result word");
                fail_count++;
            end
            else
            begin
                rsp_word_t e;
                e = digest_queue.pop_front();
                if (rsp.hash_word0 !== e.hash_word0)
                begin
                    $error("hash_word0 exp %h got %h", e.hash_word0, rsp.hash_word0);
                    fail_count++;
                end
                if (rsp.hash_word1 !== e.hash_word1)
                begin
                    $error("hash_word1 exp %h got %h", e.hash_word1, rsp.hash_word1);
                    fail_count++;
                end
                if (rsp.hash_word2 !== e.hash_word2)
                begin
                    $error("hash_word2 exp %h got %h", e.hash_word2, rsp.hash_word2);
                    fail_count++;
                end
                if (rsp.hash_word3 !== e.hash_word3)
                begin
                    $error("hash_word3 exp %h got %h", e.hash_word3, rsp.hash_word3);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int gap;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (recv_hold)
                rsp_ready <= 1'b0;
            else if (recv_idle_on && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 9);
                rsp_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                rsp_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        hash_count = 0;
        load_count = 0;
        result_count = 0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        recv_hold = 1'b0;
        profile_copy = '0;
        for (int i = 0; i < TPL_WORDS; i++)
            tpl_copy[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_profiles();
        test_backpressure();
        test_random_mix(1200);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random_mix(200);
        drain();
        $display("Covered %0d hash words and %0d load words, %0d results checked,",
                 hash_count, load_count, result_count);
        $display("all four layout profiles, stalls on both sides and a full pipeline.");
        if (fail_count == 0 && digest_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
